### design/mtee_pkg.sv
// Shared types and constants for the MIDI track event encoder.
package mtee_pkg;

    localparam int DeltaWidth = 28;
    localparam int GroupWidth = 7;
    localparam int NumGroups  = 4;

    localparam logic [7:0] ContBit   = 8'h80;
    localparam logic [6:0] GroupMask = 7'h7f;

    typedef struct packed {
        logic [DeltaWidth-1:0] delta_ticks;
        logic [7:0]            event_type;
        logic [3:0]            channel;
        logic [7:0]            first_data;
        logic [7:0]            second_data;
    } event_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_byte;
        logic [31:0] track_length;
    } result_t;

    // Classified event: delta split into groups, group count minus one,
    // status byte and the two data bytes.
    typedef struct packed {
        logic [NumGroups-1:0][GroupWidth-1:0] groups;
        logic [1:0]                           ngroups_m1;
        logic [7:0]                           status;
        logic [7:0]                           first_data;
        logic [7:0]                           second_data;
    } job_t;

endpackage

### design/midi_track_event_encoder_core.sv
// Top level of the MIDI track event encoder.
//
// Input channel evt: one request per MIDI track event (delta time, event
// type, channel, two data bytes), taken when evt_valid is high and
// evt_stall low. Output channel res: one request per encoded byte, with a
// last_byte flag on the final byte and the running track byte count.
// Each event yields 4 to 7 bytes: 1 to 4 delta bytes (variable-length
// quantity, most significant group first), status, first and second data.
// Path: when the path is empty, the first byte of an event passes the front
// register, queue write, serializer load and output reg, in that order.
// Throughput: one byte per cycle while res_stall is low, set by the
// single-byte output register; the two-entry queue lets the front end
// keep accepting events while the serializer works.
// Reset clears all valid flags and the track byte count to zero.
// While res_stall is high the output byte holds and the serializer waits;
// the queue then fills and evt_stall rises.
module midi_track_event_encoder_core
    import mtee_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    evt_valid,
    output logic    evt_stall,
    input  event_t  evt,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res
);

    logic f_valid;
    logic f_stall;
    job_t f_job;
    logic q_valid;
    logic q_stall;
    job_t q_job;

    mtee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .job_valid (f_valid),
        .job_stall (f_stall),
        .job       (f_job)
    );

    mtee_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_stall (f_stall),
        .wr_job   (f_job),
        .rd_valid (q_valid),
        .rd_stall (q_stall),
        .rd_job   (q_job)
    );

    mtee_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_stall (q_stall),
        .job       (q_job),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

### design/mtee_front.sv
// Front end: accepts event requests and splits the delta into 7-bit groups.
module mtee_front
    import mtee_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   evt_valid,
    output logic   evt_stall,
    input  event_t evt,
    output logic   job_valid,
    input  logic   job_stall,
    output job_t   job
);

    logic valid_reg;
    job_t job_reg;
    job_t job_next;

    always_comb
    begin
        job_next.groups[0]   = evt.delta_ticks[6:0]   & GroupMask;
        job_next.groups[1]   = evt.delta_ticks[13:7]  & GroupMask;
        job_next.groups[2]   = evt.delta_ticks[20:14] & GroupMask;
        job_next.groups[3]   = evt.delta_ticks[27:21] & GroupMask;
        job_next.status      = evt.event_type | {4'h0, evt.channel};
        job_next.first_data  = evt.first_data;
        job_next.second_data = evt.second_data;
        priority if (evt.delta_ticks[27:21] != '0)
            job_next.ngroups_m1 = 2'd3;
        else if (evt.delta_ticks[20:14] != '0)
            job_next.ngroups_m1 = 2'd2;
        else if (evt.delta_ticks[13:7] != '0)
            job_next.ngroups_m1 = 2'd1;
        else
            job_next.ngroups_m1 = 2'd0;
    end

    assign evt_stall = valid_reg && job_stall;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!evt_stall)
        begin
            valid_reg <= evt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!evt_stall && evt_valid)
        begin
            job_reg <= job_next;
        end
    end

endmodule

### design/mtee_queue.sv
// Two-entry queue of classified events between front and back ends.
module mtee_queue
    import mtee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_stall,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_stall,
    output job_t rd_job
);

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_stall = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

### design/mtee_back.sv
// Back end: serializes one event into bytes and keeps the track byte count.
module mtee_back
    import mtee_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_stall,
    input  job_t    job,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res
);

    logic        busy_reg;
    job_t        cur_reg;
    logic [2:0]  step_reg;
    logic [31:0] count_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        advance;
    logic        at_last;
    logic        load;
    logic [2:0]  ngroups;
    logic [1:0]  gsel;
    logic [7:0]  byte_next;
    logic [31:0] count_next;

    assign ngroups    = {1'b0, cur_reg.ngroups_m1} + 3'd1;
    assign gsel       = cur_reg.ngroups_m1 - step_reg[1:0];
    assign at_last    = (step_reg == ngroups + 3'd2);
    assign advance    = busy_reg && (!out_valid_reg || !res_stall);
    assign load       = !busy_reg || (advance && at_last);
    assign job_stall  = !load;
    assign count_next = count_reg + 32'd1;

    always_comb
    begin
        priority if (step_reg < ngroups)
            byte_next = {1'b0, cur_reg.groups[gsel]} | ((gsel != 2'd0) ? ContBit : 8'h00);
        else if (step_reg == ngroups)
            byte_next = cur_reg.status;
        else if (step_reg == ngroups + 3'd1)
            byte_next = cur_reg.first_data;
        else
            byte_next = cur_reg.second_data;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 3'd0;
            count_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= job_valid;
                step_reg <= 3'd0;
            end
            else if (advance)
            begin
                step_reg <= step_reg + 3'd1;
            end

            if (advance)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && job_valid)
            cur_reg <= job;
        if (advance)
        begin
            out_reg.out_byte     <= byte_next;
            out_reg.last_byte    <= at_last;
            out_reg.track_length <= count_next;
        end
    end

endmodule

### design/mtee_checker.sv
// Port-level checks for the MIDI track event encoder, bound to the top level.
module mtee_checker
    import mtee_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_stall,
    input result_t res
);

    logic [31:0] prev_len_reg;
    logic [2:0]  nbytes_reg;
    logic        res_take;

    assign res_take = res_valid && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_len_reg <= 32'd0;
            nbytes_reg   <= 3'd0;
        end
        else if (res_take)
        begin
            prev_len_reg <= res.track_length;
            nbytes_reg   <= res.last_byte ? 3'd0 : nbytes_reg + 3'd1;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |-> res.track_length == prev_len_reg + 32'd1)
        else $error("track length did not advance by one");

    a_max_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |-> nbytes_reg <= 3'd6)
        else $error("event longer than seven bytes");

    a_min_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && res.last_byte |-> nbytes_reg >= 3'd3)
        else $error("event shorter than four bytes");

endmodule

bind midi_track_event_encoder_core mtee_checker u_mtee_checker (.*);

### sim/midi_event_byte_checker.sv
// Checker for the MIDI track event encoder: predicts encoded bytes and compares them.
`timescale 1ns / 1ps

module midi_event_byte_checker
    import mtee_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    evt_valid,
    input  logic    evt_stall,
    input  event_t  evt,
    input  logic    res_valid,
    input  logic    res_stall,
    input  result_t res,
    output int      mismatches,
    output int      pending
);

    result_t     expected_bytes[$];
    logic [31:0] byte_count = '0;

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic push_byte(input logic [7:0] value, input logic last);
        result_t r;
        byte_count     = byte_count + 32'd1;
        r.out_byte     = value;
        r.last_byte    = last;
        r.track_length = byte_count;
        expected_bytes.push_back(r);
    endtask

    // Delta as variable-length quantity, MS group first, then status and data.
    task automatic encode_event(input event_t e);
        logic [GroupWidth-1:0] grp [NumGroups];
        logic [DeltaWidth-1:0] d;
        logic [7:0]            b;
        int                    n;
        d = e.delta_ticks;
        n = 0;
        do
        begin
            grp[n] = d[GroupWidth-1:0];
            n++;
            d = d >> GroupWidth;
        end
        while (d != '0 && n < NumGroups);
        for (int g = n - 1; g >= 0; g--)
        begin
            b = {1'b0, grp[g]};
            if (g != 0)
                b = b | ContBit;
            push_byte(b, 1'b0);
        end
        push_byte(e.event_type | {4'h0, e.channel}, 1'b0);
        push_byte(e.first_data, 1'b0);
        push_byte(e.second_data, 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            byte_count = '0;
            expected_bytes.delete();
        end
        else
        begin
            if (evt_valid && !evt_stall)
                encode_event(evt);
            if (res_valid && !res_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected byte %02h last %0d len %0d",
                                 res.out_byte, res.last_byte, res.track_length);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (res.out_byte !== want.out_byte || res.last_byte !== want.last_byte
                        || res.track_length !== want.track_length)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected byte %02h last %0d len %0d, got byte %02h last %0d len %0d",
                                     want.out_byte, want.last_byte, want.track_length,
                                     res.out_byte, res.last_byte, res.track_length);
                    end
                end
            end
        end
        pending = expected_bytes.size();
    end

endmodule

### sim/tb_midi_track_event_encoder_core.sv
// Testbench top for the MIDI track event encoder: reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_midi_track_event_encoder_core;
    import mtee_pkg::*;

    localparam int LongHold   = 120;
    localparam int DrainWait  = 20;
    localparam int NumRandom  = 214;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    evt_valid = 1'b0;
    logic    evt_stall;
    event_t  evt = '0;
    logic    res_valid;
    logic    res_stall = 1'b0;
    result_t res;

    int      mismatches;
    int      pending;

    bit      tx_idle = 1'b1;
    bit      rx_idle = 1'b1;
    bit      rx_hold_req = 1'b0;

    always #5 clk = ~clk;

    midi_track_event_encoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    midi_event_byte_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic event_t make_event(input logic [27:0] delta, input logic [7:0] etype,
                                          input logic [3:0] chan, input logic [7:0] d1,
                                          input logic [7:0] d2);
        event_t e;
        e.delta_ticks = delta;
        e.event_type  = etype;
        e.channel     = chan;
        e.first_data  = d1;
        e.second_data = d2;
        return e;
    endfunction

    function automatic event_t random_event();
        event_t      e;
        logic [3:0]  hi;
        case ($urandom_range(0, 4))
            0: e.delta_ticks = 28'($urandom_range(0, 127));
            1: e.delta_ticks = 28'($urandom_range(128, 16383));
            2: e.delta_ticks = 28'($urandom_range(16384, 2097151));
            3: e.delta_ticks = 28'($urandom_range(2097152, 268435455));
            default: e.delta_ticks = 28'($urandom);
        endcase
        hi = 4'($urandom_range(8, 15));
        if ($urandom_range(0, 3) == 0)
            e.event_type = 8'($urandom_range(0, 255));
        else
            e.event_type = {hi, 4'h0};
        e.channel     = 4'($urandom_range(0, 15));
        e.first_data  = 8'($urandom_range(0, 255));
        e.second_data = 8'($urandom_range(0, 255));
        return e;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_event(input event_t e);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            evt_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt       = e;
        evt_valid = 1'b1;
        do
            @(posedge clk);
        while (evt_stall);
        @(negedge clk);
    endtask

    // Receiver flow control
    initial
    begin
        int n;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                res_stall   = 1'b1;
                repeat (LongHold) @(negedge clk);
            end
            n = rx_idle ? $urandom_range(0, 15) : 0;
            if (n > 0)
            begin
                res_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            res_stall = 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // delta group boundaries, every status type, overlap and extremes
        send_event(make_event(28'h0000000, 8'h90, 4'h0, 8'h3C, 8'h64));
        send_event(make_event(28'h000007F, 8'h80, 4'hF, 8'h00, 8'h00));
        send_event(make_event(28'h0000080, 8'hA0, 4'h1, 8'hFF, 8'hFF));
        send_event(make_event(28'h0003FFF, 8'hB0, 4'h2, 8'h7F, 8'h80));
        send_event(make_event(28'h0004000, 8'hC0, 4'h3, 8'h80, 8'h7F));
        send_event(make_event(28'h01FFFFF, 8'hD0, 4'h4, 8'h01, 8'hFE));
        send_event(make_event(28'h0200000, 8'hE0, 4'h5, 8'hAA, 8'h55));
        send_event(make_event(28'hFFFFFFF, 8'hF0, 4'h6, 8'h55, 8'hAA));
        send_event(make_event(28'h0000000, 8'h9F, 4'h5, 8'h00, 8'hFF));
        send_event(make_event(28'hAAAAAAA, 8'hFF, 4'hF, 8'hFF, 8'hFF));
        send_event(make_event(28'h5555555, 8'h00, 4'h0, 8'h00, 8'h00));
        send_event(make_event(28'h0000001, 8'h8F, 4'h0, 8'h7F, 8'h7F));
        send_event(make_event(28'h0102030, 8'h93, 4'h9, 8'h40, 8'h40));
        send_event(make_event(28'hFFFFFFF, 8'hFF, 4'hF, 8'hFF, 8'hFF));
        send_event(make_event(28'h0000000, 8'h00, 4'h0, 8'h00, 8'h00));
        send_event(make_event(28'h0000081, 8'h6A, 4'hA, 8'hC3, 8'h3C));

        // back-to-back burst with a long output hold-off to fill the block
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        rx_hold_req = 1'b1;
        for (int i = 0; i < NumRandom; i++)
        begin
            if (i == 60)
            begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end
            if (i == 150)
                rx_idle = 1'b0;
            if (i == 180)
                tx_idle = 1'b0;
            if (i == 195)
            begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end
            send_event(random_event());
        end
        evt_valid = 1'b0;

        wait (pending == 0);
        repeat (DrainWait) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
